// File: rtl/fcbc_pkg.sv
// Package for the flash CRC-16 background check unit.
// Holds the status codes, configuration register indexes, result type and CRC byte update.
// No dependencies.
package fcbc_pkg;

  localparam int CRC_W = 16;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h90D9;
  localparam logic [CRC_W-1:0] CHECK_LENGTH_RESET = 16'hFFFE;
  localparam logic [CRC_W-1:0] EXPECTED_CRC_RESET = 16'h0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHECK_LENGTH = 1'b0,
    REG_EXPECTED_CRC = 1'b1
  } cfg_reg_t;

  // Status reported with every result.
  typedef enum logic [1:0] {
    STATUS_ABSORBED = 2'd0,
    STATUS_PASS_GOOD = 2'd1,
    STATUS_MISMATCH = 2'd2,
    STATUS_HALTED_IDLE = 2'd3
  } status_t;

  // One result transaction.
  typedef struct packed {
    logic [CRC_W-1:0] fetch_address;
    logic [CRC_W-1:0] crc_value;
    status_t status;
    logic shutdown;
  } result_t;

  // MSB-first CRC-16 update by one byte, no reflection.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int i = 0; i < BYTE_W; i++) begin
      if (crc[CRC_W-1]) begin
        crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[CRC_W-2:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// File: rtl/fcbc_core.sv
// State and next-state logic of the flash CRC-16 background check.
// Holds the configuration registers, address/CRC with complement copies and the halt flag.
// Depends on fcbc_pkg.
module fcbc_core #(
  parameter int ADDR_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write_en,
  input  logic [fcbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcbc_pkg::CRC_W-1:0] cfg_data,
  input  logic fire,
  input  logic [fcbc_pkg::BYTE_W-1:0] flash_byte,
  output fcbc_pkg::result_t result
);

  localparam int CMP_W = (ADDR_BITS > fcbc_pkg::CRC_W) ? ADDR_BITS : fcbc_pkg::CRC_W;

  logic [fcbc_pkg::CRC_W-1:0] check_length;
  logic [fcbc_pkg::CRC_W-1:0] expected_crc;

  logic [ADDR_BITS-1:0] address, address_next;
  logic [ADDR_BITS-1:0] address_complement, address_complement_next;
  logic [fcbc_pkg::CRC_W-1:0] crc_reg, crc_reg_next;
  logic [fcbc_pkg::CRC_W-1:0] crc_complement, crc_complement_next;
  logic [fcbc_pkg::BYTE_W-1:0] last_byte, last_byte_next;
  logic halted, halted_next;
  logic fault_seen, fault_seen_next;

  logic addr_ok;
  logic crc_ok;
  logic in_range;
  logic [CMP_W-1:0] address_wide;
  fcbc_pkg::status_t status;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      check_length <= fcbc_pkg::CHECK_LENGTH_RESET;
      expected_crc <= fcbc_pkg::EXPECTED_CRC_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        fcbc_pkg::REG_CHECK_LENGTH: check_length <= cfg_data;
        fcbc_pkg::REG_EXPECTED_CRC: expected_crc <= cfg_data;
        default: ;
      endcase
    end
  end

  // Complement checks and the end-of-pass compare.
  assign addr_ok = (address ^ address_complement) == {ADDR_BITS{1'b1}};
  assign crc_ok = (crc_reg ^ crc_complement) == {fcbc_pkg::CRC_W{1'b1}};
  assign in_range = CMP_W'(address) < CMP_W'(check_length);

  // One step of the self-test.
  always_comb begin
    address_next = address;
    address_complement_next = address_complement;
    crc_reg_next = crc_reg;
    crc_complement_next = crc_complement;
    last_byte_next = last_byte;
    halted_next = halted;
    fault_seen_next = fault_seen;
    status = fcbc_pkg::STATUS_ABSORBED;
    priority if (halted) begin
      status = fcbc_pkg::STATUS_HALTED_IDLE;
    end else if (in_range) begin
      if (addr_ok) begin
        last_byte_next = flash_byte;
        address_next = address + 1'b1;
        address_complement_next = address_complement - 1'b1;
      end else begin
        fault_seen_next = 1'b1;
      end
      // A bad address copy still runs the CRC step on the previous byte.
      if (crc_ok) begin
        crc_reg_next = fcbc_pkg::crc_byte(crc_reg, last_byte_next);
        crc_complement_next = ~crc_reg_next;
      end else begin
        fault_seen_next = 1'b1;
      end
    end else if (crc_reg != expected_crc) begin
      halted_next = 1'b1;
      status = fcbc_pkg::STATUS_MISMATCH;
    end else begin
      status = fcbc_pkg::STATUS_PASS_GOOD;
      if (crc_ok) begin
        crc_reg_next = '0;
        crc_complement_next = '1;
      end else begin
        fault_seen_next = 1'b1;
      end
      if (addr_ok) begin
        address_next = '0;
        address_complement_next = '1;
      end else begin
        fault_seen_next = 1'b1;
      end
    end
  end

  // Result of this step, taken by the output register.
  assign address_wide = CMP_W'(address_next);
  assign result.fetch_address = address_wide[fcbc_pkg::CRC_W-1:0];
  assign result.crc_value = crc_reg_next;
  assign result.status = status;
  assign result.shutdown = fault_seen_next;

  // State update on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      address <= '0;
      address_complement <= '1;
      crc_reg <= '0;
      crc_complement <= '1;
      last_byte <= '0;
      halted <= 1'b0;
      fault_seen <= 1'b0;
    end else if (fire) begin
      address <= address_next;
      address_complement <= address_complement_next;
      crc_reg <= crc_reg_next;
      crc_complement <= crc_complement_next;
      last_byte <= last_byte_next;
      halted <= halted_next;
      fault_seen <= fault_seen_next;
    end
  end

endmodule

// File: rtl/fcbc_out_reg.sv
// Result register of the flash CRC-16 background check.
// Holds one result transaction and drives the input stall from the output side.
// Depends on fcbc_pkg.
module fcbc_out_reg (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic out_stall,
  input  fcbc_pkg::result_t result_in,
  output logic in_stall,
  output logic fire,
  output logic out_valid,
  output fcbc_pkg::result_t result_q
);

  // A new transaction enters when the register is empty or is being emptied.
  assign in_stall = out_valid && out_stall;
  assign fire = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (fire) begin
      result_q <= result_in;
    end
  end

endmodule

// File: rtl/flash_crc16_background_check_unit.sv
// Flash CRC-16 background check unit: top level.
// The result is registered and offered in the cycle after its input is accepted.
// Throughput: one flash byte per cycle unless the result side stalls; the CRC byte
// update sits between the state and result registers. Synchronous active-high reset
// clears state and empties the result register, sets check_length to 65534, expected_crc to 0.
// Depends on fcbc_pkg, fcbc_core and fcbc_out_reg.
module flash_crc16_background_check_unit #(
  parameter int ADDR_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write_en,
  input  logic [fcbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcbc_pkg::CRC_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [fcbc_pkg::BYTE_W-1:0] flash_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic [fcbc_pkg::CRC_W-1:0] fetch_address,
  output logic [fcbc_pkg::CRC_W-1:0] crc_value,
  output logic [1:0] status,
  output logic shutdown
);

  logic fire;
  fcbc_pkg::result_t step_result;
  fcbc_pkg::result_t result_q;

  // Self-test state and step logic.
  fcbc_core #(
    .ADDR_BITS(ADDR_BITS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fire(fire),
    .flash_byte(flash_byte),
    .result(step_result)
  );

  // Result register.
  fcbc_out_reg u_out_reg (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .out_stall(out_stall),
    .result_in(step_result),
    .in_stall(in_stall),
    .fire(fire),
    .out_valid(out_valid),
    .result_q(result_q)
  );

  assign fetch_address = result_q.fetch_address;
  assign crc_value = result_q.crc_value;
  assign status = result_q.status;
  assign shutdown = result_q.shutdown;

endmodule

// File: rtl/fcbc_checker.sv
// Port-level checker for the flash CRC-16 background check unit, with its bind.
// Depends on fcbc_pkg and flash_crc16_background_check_unit.
module fcbc_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic [fcbc_pkg::CRC_W-1:0] fetch_address,
  input logic [fcbc_pkg::CRC_W-1:0] crc_value,
  input logic [1:0] status,
  input logic shutdown
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // After a mismatch the next result reports the halted state.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && status == fcbc_pkg::STATUS_MISMATCH ##1 out_valid
    |-> status == fcbc_pkg::STATUS_HALTED_IDLE)
    else $error("block did not stay halted after a mismatch");

  // A good pass restarts address and CRC at zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == fcbc_pkg::STATUS_PASS_GOOD
    |-> fetch_address == '0 && crc_value == '0)
    else $error("good pass did not restart address and CRC");

  // The shutdown flag is sticky across transactions.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && shutdown ##1 out_valid |-> shutdown)
    else $error("shutdown flag cleared without reset");

endmodule

bind flash_crc16_background_check_unit fcbc_checker u_fcbc_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .fetch_address(fetch_address),
  .crc_value(crc_value),
  .status(status),
  .shutdown(shutdown)
);

// File: dv/tb_flash_crc16_background_check_unit.sv
// Testbench for the flash CRC-16 background check unit: random and directed flash bytes,
// a scoreboard class that predicts every result transaction, and random stalls on both sides.
// Depends on fcbc_pkg and flash_crc16_background_check_unit.
module tb_flash_crc16_background_check_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fcbc_pkg::*;

  localparam int ADDR_W = 16;
  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT = 600000;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  // One MSB-first CRC-16 step over a byte.
  function automatic logic [CRC_W-1:0] crc16_next(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Tracks the self-test state, predicts each result and checks what comes out.
  class rom_check_tracker;
    logic [CRC_W-1:0] check_len;
    logic [CRC_W-1:0] ref_crc;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_inv;
    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_inv;
    logic [BYTE_W-1:0] held_byte;
    bit halted;
    bit fault;
    result_t pending_results[$];
    int errors;
    int status_hits[4];

    function new();
      check_len = CHECK_LENGTH_RESET;
      ref_crc = EXPECTED_CRC_RESET;
      addr_reg = '0;
      addr_inv = '1;
      crc_reg = '0;
      crc_inv = '1;
      held_byte = '0;
      halted = 1'b0;
      fault = 1'b0;
      errors = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    // An accepted flash byte advances the prediction by one step.
    function void absorb_byte(input logic [BYTE_W-1:0] b);
      status_t st;
      result_t r;
      if (halted) begin
        st = STATUS_HALTED_IDLE;
      end else if (addr_reg < check_len) begin
        // A broken address copy keeps the old byte and address.
        if ((addr_reg ^ addr_inv) == '1) begin
          held_byte = b;
          addr_reg = addr_reg + 1'b1;
          addr_inv = addr_inv - 1'b1;
        end else begin
          fault = 1'b1;
        end
        if ((crc_reg ^ crc_inv) == '1) begin
          crc_reg = crc16_next(crc_reg, held_byte);
          crc_inv = ~crc_reg;
        end else begin
          fault = 1'b1;
        end
        st = STATUS_ABSORBED;
      end else if (crc_reg != ref_crc) begin
        halted = 1'b1;
        st = STATUS_MISMATCH;
      end else begin
        // Good end of pass: each register restarts only if its copy agrees.
        if ((crc_reg ^ crc_inv) == '1) begin
          crc_reg = '0;
          crc_inv = '1;
        end else begin
          fault = 1'b1;
        end
        if ((addr_reg ^ addr_inv) == '1) begin
          addr_reg = '0;
          addr_inv = '1;
        end else begin
          fault = 1'b1;
        end
        st = STATUS_PASS_GOOD;
      end
      r.fetch_address = addr_reg;
      r.crc_value = crc_reg;
      r.status = st;
      r.shutdown = fault;
      pending_results.push_back(r);
    endfunction

    // Compare one result transaction with the oldest prediction.
    function void compare_result(input result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: fetch_address %h crc_value %h status %0d",
               got.fetch_address, got.crc_value, got.status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      status_hits[want.status]++;
      if (got.fetch_address !== want.fetch_address) begin
        $error("fetch_address: expected %h, actual %h", want.fetch_address, got.fetch_address);
        errors++;
      end
      if (got.crc_value !== want.crc_value) begin
        $error("crc_value: expected %h, actual %h", want.crc_value, got.crc_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.shutdown !== want.shutdown) begin
        $error("shutdown: expected %0b, actual %0b", want.shutdown, got.shutdown);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CRC_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [BYTE_W-1:0] flash_byte;
  logic out_valid;
  logic out_stall;
  logic [CRC_W-1:0] fetch_address;
  logic [CRC_W-1:0] crc_value;
  logic [1:0] status;
  logic shutdown;

  rom_check_tracker sb;
  int cycles;
  int items_sent;
  int hold_cycles;
  bit holding;
  bit quiet;
  bit gaps_on;

  flash_crc16_background_check_unit #(
    .ADDR_BITS(ADDR_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .flash_byte(flash_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .fetch_address(fetch_address),
    .crc_value(crc_value),
    .status(status),
    .shutdown(shutdown)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Both channels are sampled at the clock edge where a transaction completes.
  always @(posedge clk) begin : monitor
    result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.absorb_byte(flash_byte);
      end
      if (out_valid && !out_stall) begin
        got.fetch_address = fetch_address;
        got.crc_value = crc_value;
        got.status = status_t'(status);
        got.shutdown = shutdown;
        sb.compare_result(got);
      end
    end
  end

  // Result side: random stall bursts, a long hold on request, none in the quiet part.
  initial begin : receiver
    int span;
    out_stall = 1'b0;
    holding = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_cycles > 0 && !holding) begin
        span = hold_cycles;
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
        holding = 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  function automatic byte_q_t random_bytes(input int n);
    byte_q_t q;
    repeat (n) q.push_back(BYTE_W'($urandom_range(0, 255)));
    return q;
  endfunction

  function automatic logic [CRC_W-1:0] crc_of(input byte_q_t q);
    logic [CRC_W-1:0] c;
    c = '0;
    foreach (q[i]) c = crc16_next(c, q[i]);
    return c;
  endfunction

  // Offer one flash byte and wait until the transaction completes.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    in_valid <= 1'b1;
    flash_byte <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
  endtask

  // Random sender gap before a transaction.
  task automatic maybe_gap();
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write both registers; only called while the block is idle.
  task automatic set_config(input logic [CRC_W-1:0] len, input logic [CRC_W-1:0] ref_crc);
    cfg_write_en <= 1'b1;
    cfg_index <= REG_CHECK_LENGTH;
    cfg_data <= len;
    @(posedge clk);
    sb.check_len = len;
    cfg_index <= REG_EXPECTED_CRC;
    cfg_data <= ref_crc;
    @(posedge clk);
    sb.ref_crc = ref_crc;
    cfg_write_en <= 1'b0;
  endtask

  // Full passes over one data set, each closed by an end-of-pass transaction.
  // With corrupt set, the stored CRC is wrong and the block halts.
  task automatic run_pass(input byte_q_t data, input int reps, input bit corrupt);
    logic [CRC_W-1:0] good;
    good = crc_of(data);
    if (corrupt) begin
      set_config(CRC_W'(data.size()), (good == 16'hFFFF) ? 16'h0000 : 16'hFFFF);
    end else begin
      set_config(CRC_W'(data.size()), good);
    end
    repeat (reps) begin
      foreach (data[i]) begin
        maybe_gap();
        send_byte(data[i]);
      end
      maybe_gap();
      send_byte(BYTE_W'($urandom_range(0, 255)));
    end
    drain();
  endtask

  // Start under a length no shorter than the data, then shrink it to the bytes absorbed so far.
  task automatic run_cut_pass(input byte_q_t data, input logic [CRC_W-1:0] first_len,
                              input logic [CRC_W-1:0] first_crc);
    set_config(first_len, first_crc);
    foreach (data[i]) begin
      maybe_gap();
      send_byte(data[i]);
    end
    drain();
    set_config(sb.addr_reg, sb.crc_reg);
    send_byte(BYTE_W'($urandom_range(0, 255)));
    drain();
  endtask

  // Zero length: every transaction ends a pass at once.
  task automatic run_zero_length(input int n);
    set_config('0, sb.crc_reg);
    repeat (n) begin
      maybe_gap();
      send_byte(BYTE_W'($urandom_range(0, 255)));
    end
    drain();
  endtask

  initial begin : stimulus
    byte_q_t data_q;
    int kind;
    int n;
    logic [CRC_W-1:0] first_len;
    sb = new();
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = REG_CHECK_LENGTH;
    cfg_data = '0;
    in_valid = 1'b0;
    flash_byte = '0;
    items_sent = 0;
    hold_cycles = 0;
    quiet = 1'b0;
    gaps_on = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: shortest pass, all-ones bytes, zero length, longest length cut short.
    data_q = {8'h00};
    run_pass(data_q, 1, 1'b0);
    data_q = {8'hFF, 8'hFF};
    run_pass(data_q, 1, 1'b0);
    run_zero_length(3);
    data_q = {8'hA5, 8'h5A, 8'h80, 8'h01};
    run_cut_pass(data_q, 16'hFFFF, 16'hFFFF);

    // The receiver holds off while bytes keep coming, so the input backs up.
    gaps_on = 1'b0;
    hold_cycles = 60;
    while (!holding) @(posedge clk);
    hold_cycles = 0;
    run_pass(random_bytes(12), 1, 1'b0);

    // Random passes, mostly short, with some long, cut-short and zero-length ones.
    n = items_sent;
    while (items_sent < n + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 19);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (kind < 14) begin
        run_pass(random_bytes($urandom_range(1, 24)), $urandom_range(1, 3), 1'b0);
      end else if (kind < 17) begin
        run_pass(random_bytes($urandom_range(25, 150)), 1, 1'b0);
      end else if (kind < 19) begin
        data_q = random_bytes($urandom_range(0, 20));
        first_len = $urandom_range(0, 1) ? 16'hFFFF
                                         : CRC_W'($urandom_range(data_q.size(), 65535));
        run_cut_pass(data_q, first_len, CRC_W'($urandom_range(0, 65535)));
      end else begin
        run_zero_length($urandom_range(1, 4));
      end
    end

    // Final part without idling: good passes, then a wrong stored CRC halts the block.
    quiet = 1'b1;
    run_pass(random_bytes($urandom_range(1, 24)), 2, 1'b0);
    run_pass(random_bytes($urandom_range(1, 24)), 1, 1'b1);
    repeat (6) send_byte(BYTE_W'($urandom_range(0, 255)));
    drain();
    set_config(16'd1, 16'h0000);
    repeat (4) send_byte(BYTE_W'($urandom_range(0, 255)));
    drain();
    repeat (4) @(posedge clk);

    $display("Run covered %0d flash byte transactions over lengths from 0 to 65535.", items_sent);
    $display("Results: %0d absorbed, %0d good passes, %0d mismatch, %0d while halted.",
             sb.status_hits[STATUS_ABSORBED], sb.status_hits[STATUS_PASS_GOOD],
             sb.status_hits[STATUS_MISMATCH], sb.status_hits[STATUS_HALTED_IDLE]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
